@@ hdl/slcd_pkg.sv @@
// ----------------------------------------------------------------------------
// slcd_pkg
// shared types, command codes and glyph encoding for the segment lcd writer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package slcd_pkg;

   localparam int NUMBER_WIDTH = 21;
   localparam int BCD_DIGITS   = 7;
   localparam int COUNT_WIDTH  = $clog2(NUMBER_WIDTH + 1);
   localparam int POINT_PLACES = 3;

   typedef enum logic [1:0] {
      CMD_DISPLAY = 2'd0,
      CMD_DIGIT   = 2'd1,
      CMD_SET_SYM = 2'd2,
      CMD_CLR_SYM = 2'd3
   } cmd_type;

   localparam logic [4:0] GLYPH_MINUS = 5'd16;
   localparam logic [4:0] GLYPH_BLANK = 5'd31;
   localparam logic [7:0] SYM_MASK    = 8'h10;

   typedef logic [BCD_DIGITS-1:0][3:0] bcd_type;

   // glyph segments a..g in bits 0..6
   function automatic logic [6:0] glyph(input logic [4:0] code);
      logic [6:0] g;
      case (code)
         5'd0:    g = 7'h3F;
         5'd1:    g = 7'h06;
         5'd2:    g = 7'h5B;
         5'd3:    g = 7'h4F;
         5'd4:    g = 7'h66;
         5'd5:    g = 7'h6D;
         5'd6:    g = 7'h7D;
         5'd7:    g = 7'h07;
         5'd8:    g = 7'h7F;
         5'd9:    g = 7'h6F;
         5'd10:   g = 7'h77;
         5'd11:   g = 7'h7C;
         5'd12:   g = 7'h39;
         5'd13:   g = 7'h5E;
         5'd14:   g = 7'h79;
         5'd15:   g = 7'h71;
         5'd16:   g = 7'h40;
         default: g = 7'h00;
      endcase
      return g;
   endfunction

   // segments a..g land on cell bits 7,6,5,0,1,3,2; symbol on bit 4
   function automatic logic [7:0] seg_byte(input logic [4:0] code, input logic sym);
      logic [6:0] g;
      g = glyph(code);
      return {g[0], g[1], g[2], sym, g[5], g[6], g[4], g[3]};
   endfunction

endpackage

@@ hdl/segment_lcd_number_writer.sv @@
// ----------------------------------------------------------------------------
// segment_lcd_number_writer
// segment lcd memory with digit, symbol and decimal number commands
// ----------------------------------------------------------------------------
// Holds DIGIT_COUNT lcd cell bytes (cleared by reset) and runs one request at
// a time. Set digit, set symbol and clear symbol give one response for a
// valid position, none otherwise. Display number converts the magnitude to
// bcd one bit per cycle in the serial converter, then writes and returns
// every cell in order 0 up. tlast marks the final response of a request.
`timescale 1ns / 1ps

module segment_lcd_number_writer
   import slcd_pkg::*;
#(
   parameter int DIGIT_COUNT = 6
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // cmd, number, point_position, position, digit_value, zero pad
   input  logic [39:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // cell_index, cell_byte, zero pad
   output logic [15:0] rsp_tdata,
   output logic        rsp_tlast
);

   localparam int CELL_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CONV,
      S_COUNT,
      S_CELL,
      S_OUT
   } state_type;

   state_type                state_ff;
   logic [7:0]               lcd_cells_ff [DIGIT_COUNT];
   logic [CELL_W-1:0]        cell_ff;
   logic                     neg_ff;
   logic [2:0]               point_ff;
   logic [3:0]               ndig_ff;
   logic [3:0]               ndig_in;
   logic                     rsp_valid_ff;
   logic                     rsp_last_ff;
   logic [2:0]               rsp_index_ff;
   logic [7:0]               rsp_byte_ff;

   cmd_type                  req_cmd;
   logic [NUMBER_WIDTH-1:0]  req_number;
   logic [2:0]               req_point;
   logic [2:0]               req_position;
   logic [4:0]               req_digit;
   logic                     accept;
   logic [NUMBER_WIDTH-1:0]  magnitude;
   logic                     conv_done;
   bcd_type                  bcd;

   logic                     pos_ok;
   logic [CELL_W-1:0]        cell_sel;
   logic [CELL_W-1:0]        rd_cell;
   logic [7:0]               old_byte;
   logic [7:0]               single_byte;
   logic [3:0]               place;
   logic [4:0]               disp_code;
   logic                     disp_sym;
   logic [7:0]               disp_byte;

   assign req_cmd      = cmd_type'(req_tdata[1:0]);
   assign req_number   = req_tdata[22:2];
   assign req_point    = req_tdata[25:23];
   assign req_position = req_tdata[28:26];
   assign req_digit    = req_tdata[33:29];

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign magnitude  = req_number[NUMBER_WIDTH-1] ? -req_number : req_number;

   slcd_bin2bcd u_bin2bcd (
      .clock (clock),
      .reset (reset),
      .start (accept && (req_cmd == CMD_DISPLAY)),
      .bin   (magnitude),
      .done  (conv_done),
      .bcd   (bcd)
   );

   // significant digit count, at least one
   always_comb begin
      ndig_in = 4'd1;
      for (int i = 1; i < BCD_DIGITS; i++) begin
         if (bcd[i] != 4'd0) begin
            ndig_in = 4'(i + 1);
         end
      end
   end

   always_comb begin
      pos_ok   = {1'b0, req_position} < 4'(DIGIT_COUNT);
      cell_sel = (req_cmd == CMD_DIGIT) ?
                 CELL_W'(DIGIT_COUNT - 1) - req_position[CELL_W-1:0] :
                 req_position[CELL_W-1:0];
      rd_cell  = (state_ff == S_IDLE) ? cell_sel : cell_ff;
      old_byte = lcd_cells_ff[rd_cell];
      case (req_cmd)
         CMD_DIGIT:   single_byte = seg_byte(req_digit, old_byte[4]);
         CMD_SET_SYM: single_byte = old_byte | SYM_MASK;
         CMD_CLR_SYM: single_byte = old_byte & ~SYM_MASK;
         default:     single_byte = old_byte;
      endcase

      place = 4'(DIGIT_COUNT - 1) - 4'(cell_ff);
      if (place < ndig_ff) begin
         disp_code = {1'b0, bcd[place[2:0]]};
      end else if (neg_ff && (place == ndig_ff)) begin
         disp_code = GLYPH_MINUS;
      end else begin
         disp_code = GLYPH_BLANK;
      end
      if (place < 4'(POINT_PLACES)) begin
         disp_sym = ({1'b0, point_ff} == place + 4'd1);
      end else begin
         disp_sym = old_byte[4];
      end
      disp_byte = seg_byte(disp_code, disp_sym);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
         cell_ff      <= '0;
         for (int i = 0; i < DIGIT_COUNT; i++) begin
            lcd_cells_ff[i] <= 8'h00;
         end
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  if (req_cmd == CMD_DISPLAY) begin
                     neg_ff   <= req_number[NUMBER_WIDTH-1];
                     point_ff <= req_point;
                     state_ff <= S_CONV;
                  end else if (pos_ok) begin
                     lcd_cells_ff[cell_sel] <= single_byte;
                     rsp_valid_ff <= 1'b1;
                     rsp_last_ff  <= 1'b1;
                     rsp_index_ff <= 3'(cell_sel);
                     rsp_byte_ff  <= single_byte;
                     state_ff     <= S_OUT;
                  end
               end
            end
            S_CONV: begin
               if (conv_done) begin
                  state_ff <= S_COUNT;
               end
            end
            S_COUNT: begin
               ndig_ff  <= ndig_in;
               cell_ff  <= '0;
               state_ff <= S_CELL;
            end
            S_CELL: begin
               lcd_cells_ff[cell_ff] <= disp_byte;
               rsp_valid_ff <= 1'b1;
               rsp_last_ff  <= (cell_ff == CELL_W'(DIGIT_COUNT - 1));
               rsp_index_ff <= 3'(cell_ff);
               rsp_byte_ff  <= disp_byte;
               state_ff     <= S_OUT;
            end
            S_OUT: begin
               if (rsp_tready) begin
                  rsp_valid_ff <= 1'b0;
                  if (rsp_last_ff) begin
                     state_ff <= S_IDLE;
                  end else begin
                     cell_ff  <= cell_ff + 1'b1;
                     state_ff <= S_CELL;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {5'd0, rsp_byte_ff, rsp_index_ff};

endmodule

@@ hdl/slcd_bin2bcd.sv @@
// ----------------------------------------------------------------------------
// slcd_bin2bcd
// bit-serial binary to bcd converter, shift-and-add-3, one bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module slcd_bin2bcd
   import slcd_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [NUMBER_WIDTH-1:0] bin,
   output logic                    done,
   output bcd_type                 bcd
);

   logic [NUMBER_WIDTH-1:0] bin_ff;
   bcd_type                 bcd_ff;
   bcd_type                 bcd_in;
   logic [COUNT_WIDTH-1:0]  count_ff;
   logic                    busy_ff;
   logic                    done_ff;
   bcd_type                 adj;

   always_comb begin
      for (int i = 0; i < BCD_DIGITS; i++) begin
         adj[i] = (bcd_ff[i] >= 4'd5) ? bcd_ff[i] + 4'd3 : bcd_ff[i];
      end
      bcd_in = bcd_type'({adj, bin_ff[NUMBER_WIDTH-1]});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= COUNT_WIDTH'(NUMBER_WIDTH);
            bin_ff   <= bin;
            bcd_ff   <= '0;
         end else if (busy_ff) begin
            bcd_ff   <= bcd_in;
            bin_ff   <= {bin_ff[NUMBER_WIDTH-2:0], 1'b0};
            count_ff <= count_ff - 1'b1;
            if (count_ff == COUNT_WIDTH'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign bcd  = bcd_ff;

endmodule
